FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define MCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mcd_pkg.sv
// Types and constants of the motor command text decoder.
package mcd_pkg;

	localparam int unsigned MAG_W = 9;
	localparam logic [MAG_W-1:0] MAG_MAX = 9'd511;

	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_DIGIT = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd2;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] SPEED_LIMIT_RST = 8'd255;

	typedef struct packed {
		logic [1:0]       phase;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} num_t;

	typedef struct packed {
		logic signed [8:0] speed;
		logic              pin_a;
		logic              pin_b;
		logic [7:0]        duty;
	} side_t;

endpackage

FILE: rtl/mcd_num_parser.sv
// One atol-style number parser: whitespace skip, optional sign, saturating digits.
module mcd_num_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           feed,
	input  logic           clr,
	input  logic [7:0]     ch,
	output mcd_pkg::num_t  nxt
);

	mcd_pkg::num_t num_q;
	mcd_pkg::num_t fed;
	logic          digit;
	logic          ws;
	logic          acc;
	logic [3:0]    dval;
	logic [12:0]   prod;

	assign digit = (ch >= mcd_pkg::CH_ZERO) && (ch <= mcd_pkg::CH_NINE);
	assign ws    = (ch == mcd_pkg::CH_SPACE) || ((ch >= mcd_pkg::CH_TAB) && (ch <= mcd_pkg::CH_CR));
	assign dval  = 4'(ch - mcd_pkg::CH_ZERO);
	// times ten as two shifts
	assign prod  = {1'b0, num_q.mag, 3'b000} + {3'b000, num_q.mag, 1'b0} + {9'd0, dval};

	always_comb begin
		fed = num_q;
		acc = 1'b0;
		if (num_q.phase == mcd_pkg::PH_SKIP) begin
			if (ws) begin
				fed = num_q;
			end else if (ch == mcd_pkg::CH_PLUS) begin
				fed.phase = mcd_pkg::PH_DIGIT;
			end else if (ch == mcd_pkg::CH_MINUS) begin
				fed.phase = mcd_pkg::PH_DIGIT;
				fed.neg   = 1'b1;
			end else if (!digit) begin
				fed.phase = mcd_pkg::PH_DONE;
			end else begin
				fed.phase = mcd_pkg::PH_DIGIT;
				acc       = 1'b1;
			end
		end else if (num_q.phase == mcd_pkg::PH_DIGIT) begin
			if (!digit) begin
				fed.phase = mcd_pkg::PH_DONE;
			end else begin
				acc = 1'b1;
			end
		end
		if (acc) begin
			fed.mag = (prod > {4'd0, mcd_pkg::MAG_MAX}) ? mcd_pkg::MAG_MAX : prod[8:0];
		end
	end

	assign nxt = feed ? fed : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
		end else if (adv) begin
			num_q <= clr ? '0 : nxt;
		end
	end

endmodule

FILE: rtl/mcd_side_fmt.sv
// Clamp one parsed speed and derive its bridge pins and duty; all are zero on a format error.
module mcd_side_fmt (
	input  logic           [7:0] limit,
	input  logic                 err,
	input  mcd_pkg::num_t        num,
	output mcd_pkg::side_t       side
);

	logic [7:0] mag_c;
	logic       neg_nz;

	assign mag_c  = (num.mag > {1'b0, limit}) ? limit : num.mag[7:0];
	assign neg_nz = num.neg && (mag_c != 8'd0);

	always_comb begin
		side = '0;
		if (!err) begin
			side.speed = neg_nz ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
			side.pin_a = neg_nz;
			side.pin_b = !num.neg && (mag_c != 8'd0);
			side.duty  = mag_c;
		end
	end

endmodule

FILE: rtl/motor_command_text_decoder.sv
// Top level of the motor command text decoder.
// Takes one character per cycle, back to back; a character is registered on
// acceptance and parsed from that register by three small parsers (left
// field, text after the first 'R', whole string). On the word flagged tlast
// the clamped speeds, bridge pins and duties land in the output register at
// the edge that ends the parse, which raises m_tvalid. Input stalls only
// when a finished result is still held in the output register, is not
// taken this cycle, and the parsed character is also a last.
// speed_limit is written through cfg_wen/cfg_wdata and resets to 255.
`include "assert_macros.svh"

module motor_command_text_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,     // speed_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] character
	input  logic        s_tlast,       // end_of_command
	output logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] left_speed, [17:9] right_speed, [18] left_pin_a, [19] left_pin_b,
	// [20] right_pin_a, [21] right_pin_b, [29:22] left_duty, [37:30] right_duty,
	// [38] format_error, [39] zero
	output logic [39:0] m_tdata
);

	logic [7:0]     speed_limit_q;
	logic           valid_s1;
	logic [7:0]     ch_s1;
	logic           last_s1;
	logic           past_q;
	logic           comma_q;
	logic           r_q;
	logic           out_free;
	logic           adv;
	logic           comma_n;
	logic           r_n;
	logic           err;
	logic           left_feed;
	logic           ar_feed;
	mcd_pkg::num_t  left_n;
	mcd_pkg::num_t  ar_n;
	mcd_pkg::num_t  whole_n;
	mcd_pkg::num_t  right_sel;
	mcd_pkg::side_t left_side;
	mcd_pkg::side_t right_side;
	logic           out_valid_q;
	logic [39:0]    out_data_q;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= mcd_pkg::SPEED_LIMIT_RST;
		end else if (cfg_wen) begin
			speed_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// a first comma or first 'R' is consumed as a marker by its own field, not fed to it
	assign left_feed = past_q && !comma_q && (ch_s1 != mcd_pkg::CH_COMMA);
	assign ar_feed   = r_q;
	assign comma_n   = comma_q || (ch_s1 == mcd_pkg::CH_COMMA);
	assign r_n       = r_q || (ch_s1 == mcd_pkg::CH_R);
	assign err       = !comma_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			past_q  <= 1'b0;
			comma_q <= 1'b0;
			r_q     <= 1'b0;
		end else if (adv) begin
			past_q  <= !last_s1;
			comma_q <= comma_n && !last_s1;
			r_q     <= r_n && !last_s1;
		end
	end

	mcd_num_parser u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.feed   (left_feed),
		.clr    (last_s1),
		.ch     (ch_s1),
		.nxt    (left_n)
	);

	mcd_num_parser u_after_r (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.feed   (ar_feed),
		.clr    (last_s1),
		.ch     (ch_s1),
		.nxt    (ar_n)
	);

	mcd_num_parser u_whole (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.feed   (1'b1),
		.clr    (last_s1),
		.ch     (ch_s1),
		.nxt    (whole_n)
	);

	assign right_sel = r_n ? ar_n : whole_n;

	mcd_side_fmt u_left_fmt (
		.limit (speed_limit_q),
		.err   (err),
		.num   (left_n),
		.side  (left_side)
	);

	mcd_side_fmt u_right_fmt (
		.limit (speed_limit_q),
		.err   (err),
		.num   (right_sel),
		.side  (right_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && last_s1) begin
			out_data_q <= {1'b0, err, right_side.duty, left_side.duty,
				right_side.pin_b, right_side.pin_a, left_side.pin_b, left_side.pin_a,
				right_side.speed, left_side.speed};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`MCD_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && m_tdata[38], m_tdata[37:0] == 38'd0)
	`MCD_ASSERT_IMP(a_left_pins, clk, arst_n, m_tvalid, !(m_tdata[18] && m_tdata[19]))
	`MCD_ASSERT_IMP(a_ld_lim, clk, arst_n, m_tvalid, m_tdata[29:22] <= speed_limit_q)
	`MCD_ASSERT_IMP(a_rd_lim, clk, arst_n, m_tvalid, m_tdata[37:30] <= speed_limit_q)
	`MCD_ASSERT_NXT(a_last_hold, clk, arst_n, valid_s1 && last_s1 && !out_free, valid_s1 && last_s1)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the motor command text decoder.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		mcd_pkg::side_t left;
		mcd_pkg::side_t right;
		logic           format_error;
	} motor_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;       // [7:0] character
	logic        s_tlast;       // end_of_command
	logic        m_tvalid;
	logic        m_tready;
	// [8:0] left_speed, [17:9] right_speed, [18] left_pin_a, [19] left_pin_b,
	// [20] right_pin_a, [21] right_pin_b, [29:22] left_duty, [37:30] right_duty,
	// [38] format_error, [39] zero
	logic [39:0] m_tdata;

	motor_command_text_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// decoder model state
	logic [7:0]    limit_model;
	logic          seen_first;
	logic          seen_comma;
	logic          seen_r;
	mcd_pkg::num_t left_num;
	mcd_pkg::num_t after_r_num;
	mcd_pkg::num_t whole_num;
	motor_result_t results_due[$];

	logic [7:0] cmd_text[$];
	int         chars_sent;
	int         send_gap_pct;
	int         recv_stall_pct;
	int         rx_hold_left;
	int         mismatches;
	int         cycle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("motor_command_text_decoder test failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready = 1'b0;
				rx_hold_left--;
			end else begin
				m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic is_space(logic [7:0] c);
		return (c == mcd_pkg::CH_SPACE) || (c >= mcd_pkg::CH_TAB && c <= mcd_pkg::CH_CR);
	endfunction

	function automatic mcd_pkg::num_t feed_number(mcd_pkg::num_t p, logic [7:0] c);
		logic digit;
		int   v;
		digit = (c >= mcd_pkg::CH_ZERO && c <= mcd_pkg::CH_NINE);
		if (p.phase == mcd_pkg::PH_SKIP) begin
			if (is_space(c))
				return p;
			if (c == mcd_pkg::CH_PLUS) begin
				p.phase = mcd_pkg::PH_DIGIT;
				return p;
			end
			if (c == mcd_pkg::CH_MINUS) begin
				p.neg = 1'b1;
				p.phase = mcd_pkg::PH_DIGIT;
				return p;
			end
			if (!digit) begin
				p.phase = mcd_pkg::PH_DONE;
				return p;
			end
			p.phase = mcd_pkg::PH_DIGIT;
		end else if (p.phase != mcd_pkg::PH_DIGIT) begin
			return p;
		end
		if (!digit) begin
			p.phase = mcd_pkg::PH_DONE;
			return p;
		end
		// saturate instead of wrapping
		v = int'(p.mag) * 10 + int'(c) - int'(mcd_pkg::CH_ZERO);
		p.mag = (v > int'(mcd_pkg::MAG_MAX)) ? mcd_pkg::MAG_MAX : v[mcd_pkg::MAG_W-1:0];
		return p;
	endfunction

	function automatic int clamped_speed(mcd_pkg::num_t p);
		int v;
		int lim;
		v = int'(p.mag);
		lim = int'(limit_model);
		if (p.neg)
			v = -v;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v;
	endfunction

	function automatic mcd_pkg::side_t bridge_drive(int s);
		mcd_pkg::side_t d;
		int             a;
		a = (s < 0) ? -s : s;
		d.speed = s[8:0];
		d.pin_a = (s < 0);
		d.pin_b = (s > 0);
		d.duty = a[7:0];
		return d;
	endfunction

	function automatic void clear_parse();
		seen_first = 1'b0;
		seen_comma = 1'b0;
		seen_r = 1'b0;
		left_num = '0;
		after_r_num = '0;
		whole_num = '0;
	endfunction

	function automatic void predict_character(logic [7:0] c, logic last);
		motor_result_t r;
		int ls;
		int rs;
		ls = 0;
		rs = 0;
		if (c == mcd_pkg::CH_COMMA && !seen_comma)
			seen_comma = 1'b1;
		else if (seen_first && !seen_comma)
			left_num = feed_number(left_num, c);
		if (c == mcd_pkg::CH_R && !seen_r)
			seen_r = 1'b1;
		else if (seen_r)
			after_r_num = feed_number(after_r_num, c);
		whole_num = feed_number(whole_num, c);
		seen_first = 1'b1;
		if (last) begin
			r.format_error = !seen_comma;
			if (seen_comma) begin
				ls = clamped_speed(left_num);
				rs = seen_r ? clamped_speed(after_r_num) : clamped_speed(whole_num);
			end
			r.left = bridge_drive(ls);
			r.right = bridge_drive(rs);
			results_due.push_back(r);
			clear_parse();
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		motor_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result, data", int'(m_tdata[38:0]), 0);
			end else begin
				want = results_due.pop_front();
				if ($signed(m_tdata[8:0]) != want.left.speed)
					report_mismatch("left_speed", $signed(m_tdata[8:0]), want.left.speed);
				if ($signed(m_tdata[17:9]) != want.right.speed)
					report_mismatch("right_speed", $signed(m_tdata[17:9]), want.right.speed);
				if (m_tdata[18] !== want.left.pin_a)
					report_mismatch("left_pin_a", m_tdata[18], want.left.pin_a);
				if (m_tdata[19] !== want.left.pin_b)
					report_mismatch("left_pin_b", m_tdata[19], want.left.pin_b);
				if (m_tdata[20] !== want.right.pin_a)
					report_mismatch("right_pin_a", m_tdata[20], want.right.pin_a);
				if (m_tdata[21] !== want.right.pin_b)
					report_mismatch("right_pin_b", m_tdata[21], want.right.pin_b);
				if (m_tdata[29:22] !== want.left.duty)
					report_mismatch("left_duty", m_tdata[29:22], want.left.duty);
				if (m_tdata[37:30] !== want.right.duty)
					report_mismatch("right_duty", m_tdata[37:30], want.right.duty);
				if (m_tdata[38] !== want.format_error)
					report_mismatch("format_error", m_tdata[38], want.format_error);
				if (m_tdata[39] !== 1'b0)
					report_mismatch("pad bit", m_tdata[39], 0);
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_char(logic [7:0] c, logic last);
		while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = c;
		s_tlast = last;
		do
			@(posedge clk);
		while (!s_tready);
		predict_character(c, last);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < cmd_text.size(); i++)
			send_char(cmd_text[i], i == cmd_text.size() - 1);
		cmd_text.delete();
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		// let the last character finish its parse
		repeat (4) @(negedge clk);
	endtask

	task automatic set_speed_limit(logic [7:0] v);
		cfg_wen = 1'b1;
		cfg_wdata = v;
		limit_model = v;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	function automatic void add_string(string s);
		for (int i = 0; i < s.len(); i++)
			cmd_text.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? mcd_pkg::CH_SPACE : 8'(mcd_pkg::CH_TAB + r);
	endfunction

	function automatic void add_number();
		int n;
		int r;
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 2);
			repeat (n) cmd_text.push_back(pick_space());
		end
		r = $urandom_range(0, 3);
		if (r == 0)
			cmd_text.push_back(mcd_pkg::CH_PLUS);
		else if (r == 1)
			cmd_text.push_back(mcd_pkg::CH_MINUS);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
		repeat (n) cmd_text.push_back(8'(mcd_pkg::CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void build_command();
		int n;
		cmd_text.delete();
		if ($urandom_range(0, 99) < 10) begin
			n = $urandom_range(1, 8);
			repeat (n) cmd_text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		cmd_text.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : "L");
		add_number();
		if ($urandom_range(0, 9) != 0)
			cmd_text.push_back(mcd_pkg::CH_COMMA);
		if ($urandom_range(0, 99) < 85)
			cmd_text.push_back(mcd_pkg::CH_R);
		add_number();
		if ($urandom_range(0, 4) == 0)
			cmd_text.push_back(8'($urandom_range(0, 255)));
		// corrupt one byte now and then
		if ($urandom_range(0, 9) == 0)
			cmd_text[$urandom_range(0, cmd_text.size() - 1)] = 8'($urandom_range(0, 255));
	endfunction

	task automatic test_directed();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		add_string("L-12,R34");
		send_text();
		// no 'R': right speed from the whole string
		add_string("7,X");
		send_text();
		// no comma at all
		add_string("N");
		send_text();
		// comma first, sign with no digits
		add_string(",-");
		send_text();
		// whitespace, saturating digit run, bare sign after 'R'
		add_string("L \t9999,R+");
		send_text();
		// byte zero and high bytes are plain non-digits
		cmd_text = '{8'h00, 8'hFF, mcd_pkg::CH_COMMA, 8'h80, mcd_pkg::CH_R,
			mcd_pkg::CH_ZERO + 8'd5};
		send_text();
	endtask

	task automatic test_random(int gap_pct, int stall_pct, int count);
		int start;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		start = chars_sent;
		while (chars_sent - start < count) begin
			build_command();
			send_text();
		end
	endtask

	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		rx_hold_left = 250;
		// short commands keep the input busy while the output is held off
		repeat (16) begin
			cmd_text.push_back(mcd_pkg::CH_COMMA);
			cmd_text.push_back(8'(mcd_pkg::CH_ZERO + $urandom_range(0, 9)));
			send_text();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		limit_model = mcd_pkg::SPEED_LIMIT_RST;
		chars_sent = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		rx_hold_left = 0;
		mismatches = 0;
		cycle_count = 0;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		wait_drained();
		set_speed_limit(8'd0);
		test_directed();
		wait_drained();
		set_speed_limit(8'd255);
		test_random(0, 0, 300);
		wait_drained();
		set_speed_limit(8'd0);
		test_random(61, 0, 250);
		wait_drained();
		set_speed_limit(8'd100);
		test_random(0, 61, 300);
		wait_drained();
		set_speed_limit(8'($urandom_range(0, 255)));
		test_random(14, 14, 300);
		wait_drained();
		set_speed_limit(8'd1);
		test_random(14, 14, 250);
		wait_drained();
		set_speed_limit(8'd255);
		test_backpressure();
		wait_drained();

		repeat (8) @(posedge clk);
		if (results_due.size() != 0)
			report_mismatch("results never delivered", 0, results_due.size());
		if (mismatches == 0) begin
			$display("motor_command_text_decoder test passed");
		end else begin
			$display("motor_command_text_decoder test failed");
		end
		$finish;
	end

endmodule
